// File: design/kct_pkg.sv
// Shared types and constants for the k-means centroid trainer.
// No dependencies; every design file imports this package.
package kct_pkg;

  localparam int VALUE_BITS = 16;

  localparam int DEF_MAX_SAMPLES  = 1024;
  localparam int DEF_MAX_DIM      = 128;
  localparam int DEF_MAX_CLUSTERS = 32;

  typedef enum logic [1:0] {
    OP_LOAD_SAMPLE   = 2'd0,
    OP_LOAD_CENTROID = 2'd1,
    OP_RUN           = 2'd2,
    OP_READ          = 2'd3
  } kct_op_t;

  localparam logic [1:0] REG_NUM_CLUSTERS   = 2'd0;
  localparam logic [1:0] REG_VECTOR_LENGTH  = 2'd1;
  localparam logic [1:0] REG_SAMPLE_COUNT   = 2'd2;
  localparam logic [1:0] REG_MAX_ITERATIONS = 2'd3;

  // Per-cycle controls broadcast from the sequencer to every cluster cell
  typedef struct packed {
    logic dist_clr;
    logic x_valid;
    logic dist_en;
    logic acc_en;
    logic cnt_clr;
    logic cnt_inc;
    logic upd;
  } kct_ctrl_t;

endpackage

// File: design/kct_divider.sv
// Restoring divider, one quotient bit per cycle, for cluster means.
// Depends on kct_pkg.
module kct_divider import kct_pkg::*; #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int STEP_W = $clog2(NUM_W + 1);

  logic             busy;
  logic [STEP_W-1:0] steps;
  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   trial;
  logic             take;

  assign trial = {rem[DEN_W-1:0], quotient[NUM_W-1]};
  assign take  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && steps == STEP_W'(1);
      if (start) begin
        busy     <= 1'b1;
        steps    <= STEP_W'(NUM_W);
        rem      <= '0;
        den      <= divisor;
        quotient <= dividend;
      end else if (busy) begin
        rem      <= take ? trial - {1'b0, den} : trial;
        quotient <= {quotient[NUM_W-2:0], take};
        steps    <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// File: design/kct_cell.sv
// One cluster cell: centroid, older set and sum memories, squared distance
// accumulator, member count and one stage of the nearest-centroid chain.
// Depends on kct_pkg.
module kct_cell import kct_pkg::*; #(
  parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS,
  parameter int ID           = 0,
  localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
  localparam int KW   = $clog2(MAX_CLUSTERS + 1),
  localparam int EW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
  localparam int LW   = $clog2(MAX_DIM + 1),
  localparam int NW   = $clog2(MAX_SAMPLES + 1),
  localparam int SUMW = VALUE_BITS + NW,
  localparam int DW   = 2 * VALUE_BITS + LW
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kct_ctrl_t             ctrl,
  input  logic [KW-1:0]         k_eff,
  input  logic [EW-1:0]         rd_addr,
  input  logic [VALUE_BITS-1:0] x,
  input  logic [CW-1:0]         win_idx,
  input  logic                  wr_en,
  input  logic [CW-1:0]         wr_cell,
  input  logic [EW-1:0]         wr_addr,
  input  logic [VALUE_BITS-1:0] cur_wdata,
  input  logic [VALUE_BITS-1:0] older_wdata,
  input  logic                  chain_in_valid,
  input  logic [DW-1:0]         chain_in_dist,
  input  logic [CW-1:0]         chain_in_idx,
  output logic                  chain_out_valid,
  output logic [DW-1:0]         chain_out_dist,
  output logic [CW-1:0]         chain_out_idx,
  output logic [VALUE_BITS-1:0] cur_q,
  output logic [VALUE_BITS-1:0] older_q,
  output logic [SUMW-1:0]       sum_q,
  output logic [NW-1:0]         cnt
);

  localparam logic [CW-1:0] MY_ID = CW'(ID);

  logic [VALUE_BITS-1:0] cur_mem   [MAX_DIM];
  logic [VALUE_BITS-1:0] older_mem [MAX_DIM];
  logic [SUMW-1:0]       sum_mem   [MAX_DIM];

  logic                    mine;
  logic                    sel;
  logic                    in_use;
  logic [VALUE_BITS-1:0]   diff;
  logic [2*VALUE_BITS-1:0] sq;
  logic                    sq_valid;
  logic [DW-1:0]           acc;
  logic [EW-1:0]           addr_d;
  logic [SUMW-1:0]         sum_base;

  assign mine     = win_idx == MY_ID;
  assign sel      = wr_cell == MY_ID;
  assign in_use   = 32'(k_eff) > ID;
  assign diff     = (x > cur_q) ? x - cur_q : cur_q - x;
  assign sum_base = (cnt == '0) ? '0 : sum_q;

  always_ff @(posedge clk) begin
    if (wr_en && sel) begin
      cur_mem[wr_addr] <= cur_wdata;
    end
    if (wr_en && sel && ctrl.upd) begin
      older_mem[wr_addr] <= older_wdata;
    end
    if (ctrl.x_valid && ctrl.acc_en && mine) begin
      sum_mem[addr_d] <= sum_base + SUMW'(x);
    end
    cur_q   <= cur_mem[rd_addr];
    older_q <= older_mem[rd_addr];
    sum_q   <= sum_mem[rd_addr];
    addr_d  <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid        <= 1'b0;
      chain_out_valid <= 1'b0;
    end else begin
      sq_valid        <= ctrl.x_valid && ctrl.dist_en;
      chain_out_valid <= chain_in_valid;
    end
    sq <= diff * diff;
    if (ctrl.dist_clr) begin
      acc <= '0;
    end else if (sq_valid) begin
      acc <= acc + DW'(sq);
    end
    if (ctrl.cnt_clr) begin
      cnt <= '0;
    end else if (ctrl.cnt_inc && mine) begin
      cnt <= cnt + NW'(1);
    end
    // take the lead when strictly nearer; the first cell always does
    if (in_use && (ID == 0 || acc < chain_in_dist)) begin
      chain_out_dist <= acc;
      chain_out_idx  <= MY_ID;
    end else begin
      chain_out_dist <= chain_in_dist;
      chain_out_idx  <= chain_in_idx;
    end
  end

endmodule

// File: design/kmeans_centroid_trainer_unit.sv
// K-means centroid trainer: cluster cell row, sample memory and shared divider.
// Depends on kct_pkg, kct_cell, kct_divider.
// Loads are accepted back to back while idle; a read result passes through S_RD_WAIT
// and S_RD_OUT, an out-of-range read only through S_RD_OUT, and waits there until the output is free.
// A run iteration walks each sample through distance, chain and accumulate passes, then
// divides for the mean update; reset restores config and control state, memories keep data.
module kmeans_centroid_trainer_unit import kct_pkg::*; #(
  parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
  parameter int MAX_DIM      = DEF_MAX_DIM,
  parameter int MAX_CLUSTERS = DEF_MAX_CLUSTERS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        s_tvalid,
  output logic        s_tready,
  // operation[1:0], vector_index[11:2], element_index[18:12], value[34:19]
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_value[15:0], iterations_used[31:16], converged[32], status[33]
  output logic [39:0] m_tdata
);

  localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int KW   = $clog2(MAX_CLUSTERS + 1);
  localparam int EW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int LW   = $clog2(MAX_DIM + 1);
  localparam int SW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int NW   = $clog2(MAX_SAMPLES + 1);
  localparam int SDEP = MAX_SAMPLES * MAX_DIM;
  localparam int SAW  = (SDEP > 1) ? $clog2(SDEP) : 1;
  localparam int SUMW = VALUE_BITS + NW;
  localparam int DW   = 2 * VALUE_BITS + LW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_WAIT, S_RD_OUT, S_IT_START, S_DIST, S_DIST_WAIT, S_CHAIN,
    S_ACC, S_ACC_WAIT, S_UPD_RD, S_UPD_WAIT, S_UPD_DIV, S_UPD_WR, S_ITER_END,
    S_RUN_OUT
  } state_t;

  state_t state;

  // configuration
  logic [5:0]  num_clusters;
  logic [7:0]  vector_length;
  logic [10:0] sample_count;
  logic [15:0] iter_limit;
  logic        cfg_we;

  logic [KW-1:0] k_eff;
  logic [LW-1:0] len_eff;
  logic [NW-1:0] n_eff;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_clusters  <= 6'd8;
      vector_length <= 8'd1;
      sample_count  <= 11'd0;
      iter_limit    <= 16'd100;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_NUM_CLUSTERS:   num_clusters  <= pwdata[5:0];
        REG_VECTOR_LENGTH:  vector_length <= pwdata[7:0];
        REG_SAMPLE_COUNT:   sample_count  <= pwdata[10:0];
        REG_MAX_ITERATIONS: iter_limit    <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_NUM_CLUSTERS:   prdata = 32'(num_clusters);
      REG_VECTOR_LENGTH:  prdata = 32'(vector_length);
      REG_SAMPLE_COUNT:   prdata = 32'(sample_count);
      REG_MAX_ITERATIONS: prdata = 32'(iter_limit);
    endcase
  end

  assign k_eff = (num_clusters == 6'd0) ? KW'(1) :
                 (32'(num_clusters) > MAX_CLUSTERS) ? KW'(MAX_CLUSTERS) :
                 KW'(num_clusters);
  assign len_eff = (vector_length == 8'd0) ? LW'(1) :
                   (32'(vector_length) > MAX_DIM) ? LW'(MAX_DIM) :
                   LW'(vector_length);
  assign n_eff = (32'(sample_count) > MAX_SAMPLES) ? NW'(MAX_SAMPLES) :
                 NW'(sample_count);

  // input fields
  kct_op_t               in_op;
  logic [9:0]            in_vi;
  logic [6:0]            in_ei;
  logic [VALUE_BITS-1:0] in_val;
  logic                  in_fire;
  logic                  vi_smp_ok;
  logic                  vi_cen_ok;
  logic                  ei_ok;
  logic                  rd_ok;

  assign in_op     = kct_op_t'(s_tdata[1:0]);
  assign in_vi     = s_tdata[11:2];
  assign in_ei     = s_tdata[18:12];
  assign in_val    = s_tdata[34:19];
  assign s_tready  = state == S_IDLE;
  assign in_fire   = s_tvalid && s_tready;
  assign vi_smp_ok = 32'(in_vi) < MAX_SAMPLES;
  assign vi_cen_ok = 32'(in_vi) < MAX_CLUSTERS;
  assign ei_ok     = 32'(in_ei) < MAX_DIM;
  assign rd_ok     = (32'(in_vi) < 32'(k_eff)) && (32'(in_ei) < 32'(len_eff));

  // sequencer registers
  logic [SW-1:0]         s_idx;
  logic [SAW-1:0]        s_base;
  logic [EW-1:0]         e_idx;
  logic [CW-1:0]         c_idx;
  logic [1:0]            wcnt;
  logic [15:0]           it;
  logic                  older_v;
  logic                  eq_prev;
  logic                  eq_old;
  logic [CW-1:0]         win;
  logic [CW-1:0]         rd_c;
  logic [VALUE_BITS-1:0] cur_l;
  logic [VALUE_BITS-1:0] older_l;
  logic [NW-1:0]         cnt_l;
  logic [VALUE_BITS-1:0] new_l;
  logic [VALUE_BITS-1:0] rv_l;
  logic                  st_l;
  logic [15:0]           run_iters;
  logic                  run_conv;
  logic [VALUE_BITS-1:0] out_rv;
  logic [15:0]           out_iters;
  logic                  out_conv;
  logic                  out_status;
  logic                  div_start;
  logic                  div_done;
  logic [SUMW-1:0]       div_q;
  logic                  out_free;
  logic                  e_last;
  logic                  c_last;
  logic                  s_last;
  logic                  conv_now;

  assign out_free = !m_tvalid || m_tready;
  assign e_last   = LW'(e_idx) == len_eff - LW'(1);
  assign c_last   = KW'(c_idx) == k_eff - KW'(1);
  assign s_last   = NW'(s_idx) == n_eff - NW'(1);
  assign conv_now = eq_prev || (older_v && eq_old);
  assign m_tdata  = {6'b0, out_status, out_conv, out_iters, out_rv};

  // sample memory, read registered
  logic [VALUE_BITS-1:0] smem [SDEP];
  logic [VALUE_BITS-1:0] x_r;
  logic [SAW-1:0]        s_waddr;
  logic                  s_we;

  assign s_waddr = SAW'(in_vi) * SAW'(MAX_DIM) + SAW'(in_ei);
  assign s_we    = in_fire && in_op == OP_LOAD_SAMPLE && vi_smp_ok && ei_ok;

  always_ff @(posedge clk) begin
    if (s_we) begin
      smem[s_waddr] <= in_val;
    end
    x_r <= smem[s_base + SAW'(e_idx)];
  end

  // cell controls
  kct_ctrl_t             ctrl;
  logic                  xv_r;
  logic                  dist_r;
  logic                  acc_r;
  logic                  load_cen;
  logic                  cell_we;
  logic [CW-1:0]         cell_wcell;
  logic [EW-1:0]         cell_waddr;
  logic [VALUE_BITS-1:0] cell_wdata;
  logic [EW-1:0]         rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      xv_r   <= 1'b0;
      dist_r <= 1'b0;
      acc_r  <= 1'b0;
    end else begin
      xv_r   <= state == S_DIST || state == S_ACC;
      dist_r <= state == S_DIST;
      acc_r  <= state == S_ACC;
    end
  end

  assign ctrl.dist_clr = state == S_DIST && e_idx == '0;
  assign ctrl.x_valid  = xv_r;
  assign ctrl.dist_en  = dist_r;
  assign ctrl.acc_en   = acc_r;
  assign ctrl.cnt_clr  = state == S_IT_START;
  assign ctrl.cnt_inc  = state == S_ACC_WAIT;
  assign ctrl.upd      = state == S_UPD_WR;

  assign load_cen   = in_fire && in_op == OP_LOAD_CENTROID && vi_cen_ok && ei_ok;
  assign cell_we    = load_cen || ctrl.upd;
  assign cell_wcell = ctrl.upd ? c_idx : CW'(in_vi);
  assign cell_waddr = ctrl.upd ? e_idx : EW'(in_ei);
  assign cell_wdata = ctrl.upd ? new_l : in_val;
  assign rd_addr    = (state == S_IDLE) ? EW'(in_ei) : e_idx;

  // cell row
  logic                  ch_valid [MAX_CLUSTERS+1];
  logic [DW-1:0]         ch_dist  [MAX_CLUSTERS+1];
  logic [CW-1:0]         ch_idx   [MAX_CLUSTERS+1];
  logic [VALUE_BITS-1:0] cur_a    [MAX_CLUSTERS];
  logic [VALUE_BITS-1:0] older_a  [MAX_CLUSTERS];
  logic [SUMW-1:0]       sum_a    [MAX_CLUSTERS];
  logic [NW-1:0]         cnt_a    [MAX_CLUSTERS];

  assign ch_valid[0] = state == S_DIST_WAIT && wcnt == 2'd0;
  assign ch_dist[0]  = '0;
  assign ch_idx[0]   = '0;

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    kct_cell #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .MAX_DIM     (MAX_DIM),
      .MAX_CLUSTERS(MAX_CLUSTERS),
      .ID          (g)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .ctrl           (ctrl),
      .k_eff          (k_eff),
      .rd_addr        (rd_addr),
      .x              (x_r),
      .win_idx        (win),
      .wr_en          (cell_we),
      .wr_cell        (cell_wcell),
      .wr_addr        (cell_waddr),
      .cur_wdata      (cell_wdata),
      .older_wdata    (cur_l),
      .chain_in_valid (ch_valid[g]),
      .chain_in_dist  (ch_dist[g]),
      .chain_in_idx   (ch_idx[g]),
      .chain_out_valid(ch_valid[g+1]),
      .chain_out_dist (ch_dist[g+1]),
      .chain_out_idx  (ch_idx[g+1]),
      .cur_q          (cur_a[g]),
      .older_q        (older_a[g]),
      .sum_q          (sum_a[g]),
      .cnt            (cnt_a[g])
    );
  end

  // the divider takes the cell outputs in the same cycle that it starts
  kct_divider #(
    .NUM_W(SUMW),
    .DEN_W(NW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sum_a[c_idx]),
    .divisor (cnt_a[c_idx]),
    .done    (div_done),
    .quotient(div_q)
  );

  assign div_start = state == S_UPD_WAIT && cnt_a[c_idx] != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready && state != S_RD_OUT && state != S_RUN_OUT) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            unique case (in_op)
              OP_LOAD_SAMPLE, OP_LOAD_CENTROID: state <= S_IDLE;
              OP_RUN: begin
                it      <= '0;
                older_v <= 1'b0;
                if (n_eff == '0 || iter_limit == 16'd0) begin
                  run_iters <= '0;
                  run_conv  <= 1'b0;
                  state     <= S_RUN_OUT;
                end else begin
                  state <= S_IT_START;
                end
              end
              OP_READ: begin
                rd_c <= CW'(in_vi);
                rv_l <= '0;
                st_l <= !rd_ok;
                state <= rd_ok ? S_RD_WAIT : S_RD_OUT;
              end
            endcase
          end
        end
        S_RD_WAIT: begin
          rv_l  <= cur_a[rd_c];
          state <= S_RD_OUT;
        end
        S_RD_OUT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_rv     <= rv_l;
            out_iters  <= '0;
            out_conv   <= 1'b0;
            out_status <= st_l;
            state      <= S_IDLE;
          end
        end
        S_IT_START: begin
          s_idx   <= '0;
          s_base  <= '0;
          e_idx   <= '0;
          eq_prev <= 1'b1;
          eq_old  <= 1'b1;
          state   <= S_DIST;
        end
        S_DIST: begin
          if (e_last) begin
            e_idx <= '0;
            wcnt  <= 2'd2;
            state <= S_DIST_WAIT;
          end else begin
            e_idx <= e_idx + EW'(1);
          end
        end
        S_DIST_WAIT: begin
          if (wcnt == 2'd0) begin
            state <= S_CHAIN;
          end else begin
            wcnt <= wcnt - 2'd1;
          end
        end
        S_CHAIN: begin
          if (ch_valid[MAX_CLUSTERS]) begin
            win   <= ch_idx[MAX_CLUSTERS];
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (e_last) begin
            state <= S_ACC_WAIT;
          end else begin
            e_idx <= e_idx + EW'(1);
          end
        end
        S_ACC_WAIT: begin
          e_idx <= '0;
          if (s_last) begin
            c_idx <= '0;
            state <= S_UPD_RD;
          end else begin
            s_idx  <= s_idx + SW'(1);
            s_base <= s_base + SAW'(MAX_DIM);
            state  <= S_DIST;
          end
        end
        S_UPD_RD: state <= S_UPD_WAIT;
        S_UPD_WAIT: begin
          cur_l   <= cur_a[c_idx];
          older_l <= older_a[c_idx];
          cnt_l   <= cnt_a[c_idx];
          // an empty cluster keeps its centroid
          if (cnt_a[c_idx] == '0) begin
            new_l <= cur_a[c_idx];
            state <= S_UPD_WR;
          end else begin
            state <= S_UPD_DIV;
          end
        end
        S_UPD_DIV: begin
          if (div_done) begin
            new_l <= VALUE_BITS'(div_q);
            state <= S_UPD_WR;
          end
        end
        S_UPD_WR: begin
          if (new_l != cur_l) begin
            eq_prev <= 1'b0;
          end
          if (new_l != older_l) begin
            eq_old <= 1'b0;
          end
          if (e_last) begin
            e_idx <= '0;
            if (c_last) begin
              state <= S_ITER_END;
            end else begin
              c_idx <= c_idx + CW'(1);
              state <= S_UPD_RD;
            end
          end else begin
            e_idx <= e_idx + EW'(1);
            state <= S_UPD_RD;
          end
        end
        S_ITER_END: begin
          if (conv_now) begin
            run_iters <= it + 16'd1;
            run_conv  <= 1'b1;
            state     <= S_RUN_OUT;
          end else if (it + 16'd1 == iter_limit) begin
            run_iters <= iter_limit;
            run_conv  <= 1'b0;
            state     <= S_RUN_OUT;
          end else begin
            it      <= it + 16'd1;
            older_v <= 1'b1;
            state   <= S_IT_START;
          end
        end
        S_RUN_OUT: begin
          if (out_free) begin
            m_tvalid   <= 1'b1;
            out_rv     <= '0;
            out_iters  <= run_iters;
            out_conv   <= run_conv;
            out_status <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_chain_in_walk: assert property (@(posedge clk) disable iff (rst)
    ch_valid[MAX_CLUSTERS] |-> state == S_CHAIN)
    else $error("chain result outside chain walk");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_UPD_DIV && cnt_l != '0)
    else $error("divider finished outside update or with empty cluster");

  a_conv_iters: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_conv |-> out_iters != 16'd0 && !out_status)
    else $error("converged result without iterations");

  a_bad_read_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_status |-> out_rv == '0 && out_iters == 16'd0)
    else $error("out-of-range read carries data");

endmodule
